// ----- rtl/assert_macros.svh -----
// Assertion macros of the SHA-1 engine RTL.
// No dependencies; included by the controller, which carries the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- rtl/sha1he_pkg.sv -----
// Shared types, constants and round functions of the SHA-1 engine.
// No dependencies; imported by the controller, datapath and top level.
package sha1he_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned NumWords  = 5;
  localparam logic [6:0]  LastRound = 7'(NumRounds - 1);
  localparam logic [2:0]  LastWord  = 3'(NumWords - 1);
  localparam logic [5:0]  LastByte  = 6'd63;
  localparam logic [5:0]  LenStart  = 6'd56;
  localparam logic [7:0]  PadMark   = 8'h80;

  localparam word_t InitHash [NumWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_e;

  // Source of the byte pushed into the block
  typedef enum logic [1:0] {
    BYTE_MSG,
    BYTE_MARK,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_e;

  // Round group, twenty rounds each
  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR1,
    PH_MAJ,
    PH_PAR2
  } phase_e;

  typedef struct packed {
    logic      push;
    byte_sel_e byte_sel;
    logic      count_bits;
    logic      round_en;
    phase_e    phase;
    logic      update;
    logic      reinit;
    logic [2:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } status_t;

  function automatic word_t sha1_f(phase_e ph, word_t b, word_t c, word_t d);
    word_t r;
    case (ph)
      PH_CH:   r = (b & c) | (~b & d);
      PH_MAJ:  r = (b & c) | (b & d) | (c & d);
      default: r = b ^ c ^ d;
    endcase
    return r;
  endfunction

  function automatic word_t sha1_k(phase_e ph);
    word_t r;
    case (ph)
      PH_CH:   r = 32'h5A827999;
      PH_PAR1: r = 32'h6ED9EBA1;
      PH_MAJ:  r = 32'h8F1BBCDC;
      default: r = 32'hCA62C1D6;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/sha1he_dp.sv -----
// Datapath of the SHA-1 engine: block shift line, bit counter,
// working variables and chaining value. Depends on sha1he_pkg.
module sha1he_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha1he_pkg::cmd_t    cmd_i,
  input  logic [7:0]          byte_i,
  output sha1he_pkg::status_t status_o,
  output sha1he_pkg::word_t   digest_o
);
  import sha1he_pkg::*;

  word_t       w_q [16];
  word_t       w_d [16];
  word_t       chain_q [NumWords];
  word_t       chain_d [NumWords];
  word_t       a_q, b_q, c_q, d_q, e_q;
  word_t       a_d, b_d, c_d, d_d, e_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [7:0]  push_byte;
  logic [63:0] len_shift;
  word_t       sched;
  word_t       temp;

  // Pick the byte for the block
  assign len_shift = bits_q >> {~fill_q[2:0], 3'b000};
  always_comb begin
    case (cmd_i.byte_sel)
      BYTE_MSG:  push_byte = byte_i;
      BYTE_MARK: push_byte = PadMark;
      BYTE_LEN:  push_byte = len_shift[7:0];
      default:   push_byte = 8'h00;
    endcase
  end

  // Message schedule and round sum
  assign sched = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
                  w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
  assign temp  = {a_q[26:0], a_q[31:27]} + sha1_f(cmd_i.phase, b_q, c_q, d_q)
               + e_q + sha1_k(cmd_i.phase) + w_q[0];

  // Shift line: bytes enter at the bottom, rounds move whole words
  always_comb begin
    for (int i = 0; i < 16; i++) w_d[i] = w_q[i];
    if (cmd_i.push) begin
      for (int i = 0; i < 15; i++) w_d[i] = {w_q[i][23:0], w_q[i + 1][31:24]};
      w_d[15] = {w_q[15][23:0], push_byte};
    end else if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) w_d[i] = w_q[i + 1];
      w_d[15] = sched;
    end
  end

  // Working variables: load at block completion, advance each round
  always_comb begin
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    if (cmd_i.push && fill_q == LastByte) begin
      a_d = chain_q[0]; b_d = chain_q[1]; c_d = chain_q[2];
      d_d = chain_q[3]; e_d = chain_q[4];
    end else if (cmd_i.round_en) begin
      a_d = temp;
      b_d = a_q;
      c_d = {b_q[1:0], b_q[31:2]};
      d_d = c_q;
      e_d = d_q;
    end
  end

  // Chaining value, fill level and bit count
  always_comb begin
    for (int i = 0; i < NumWords; i++) chain_d[i] = chain_q[i];
    fill_d = fill_q;
    bits_d = bits_q;
    if (cmd_i.push)       fill_d = fill_q + 6'd1;
    if (cmd_i.count_bits) bits_d = bits_q + 64'd8;
    if (cmd_i.update) begin
      chain_d[0] = chain_q[0] + a_q;
      chain_d[1] = chain_q[1] + b_q;
      chain_d[2] = chain_q[2] + c_q;
      chain_d[3] = chain_q[3] + d_q;
      chain_d[4] = chain_q[4] + e_q;
    end
    if (cmd_i.reinit) begin
      for (int i = 0; i < NumWords; i++) chain_d[i] = InitHash[i];
      fill_d = '0;
      bits_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWords; i++) chain_q[i] <= InitHash[i];
      fill_q <= '0;
      bits_q <= '0;
    end else begin
      for (int i = 0; i < NumWords; i++) chain_q[i] <= chain_d[i];
      fill_q <= fill_d;
      bits_q <= bits_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 16; i++) w_q[i] <= w_d[i];
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d;
  end

  assign status_o.fill = fill_q;
  assign digest_o      = (cmd_i.out_idx < 3'(NumWords)) ? chain_q[cmd_i.out_idx] : chain_q[0];

endmodule

// ----- rtl/sha1he_ctrl.sv -----
// Controller of the SHA-1 engine: request handshakes, padding sequence,
// round count and digest output. Depends on sha1he_pkg, assert_macros.svh.
module sha1he_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_kind_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          out_index_o,
  output logic                out_last_o,
  input  sha1he_pkg::status_t status_i,
  output sha1he_pkg::cmd_t    cmd_o
);
  import sha1he_pkg::*;

  `include "assert_macros.svh"

  state_e     state_q, state_d;
  logic [6:0] round_q, round_d;
  logic [2:0] idx_q, idx_d;
  logic       pad_q, pad_d;
  logic       first_q, first_d;
  logic       len_q, len_d;
  logic       final_q, final_d;
  logic       block_end;
  logic       out_done;

  assign block_end = status_i.fill == LastByte;
  assign out_done  = state_q == ST_OUT && out_ready_i && idx_q == LastWord;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i)      state_d = ST_PAD;
          else if (block_end) state_d = ST_ROUND;
        end
      end
      ST_PAD: begin
        if (block_end) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_q == LastRound) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (final_q)    state_d = ST_OUT;
        else if (pad_q) state_d = ST_PAD;
        else            state_d = ST_IDLE;
      end
      ST_OUT: begin
        if (out_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.byte_sel   = BYTE_MSG;
    cmd_o.out_idx    = idx_q;
    in_ready_o       = state_q == ST_IDLE;
    out_valid_o      = state_q == ST_OUT;
    out_index_o      = idx_q;
    out_last_o       = idx_q == LastWord;
    if (round_q < 7'd20)      cmd_o.phase = PH_CH;
    else if (round_q < 7'd40) cmd_o.phase = PH_PAR1;
    else if (round_q < 7'd60) cmd_o.phase = PH_MAJ;
    else                      cmd_o.phase = PH_PAR2;
    case (state_q)
      ST_IDLE: begin
        cmd_o.push       = in_valid_i && !in_kind_i;
        cmd_o.count_bits = in_valid_i && !in_kind_i;
      end
      ST_PAD: begin
        cmd_o.push = 1'b1;
        if (first_q)                             cmd_o.byte_sel = BYTE_MARK;
        else if (len_q && status_i.fill >= LenStart) cmd_o.byte_sel = BYTE_LEN;
        else                                     cmd_o.byte_sel = BYTE_ZERO;
      end
      ST_ROUND:  cmd_o.round_en = 1'b1;
      ST_UPDATE: cmd_o.update   = 1'b1;
      ST_OUT:    cmd_o.reinit   = out_done;
      default:   cmd_o.push     = 1'b0;
    endcase
  end

  // Counters and padding flags
  always_comb begin
    round_d = round_q;
    idx_d   = idx_q;
    pad_d   = pad_q;
    first_d = first_q;
    len_d   = len_q;
    final_d = final_q;
    if (state_q == ST_ROUND) round_d = (round_q == LastRound) ? '0 : round_q + 7'd1;
    if (state_q == ST_OUT && out_ready_i) idx_d = out_done ? '0 : idx_q + 3'd1;
    if (state_q == ST_IDLE && in_valid_i && in_kind_i) begin
      pad_d   = 1'b1;
      first_d = 1'b1;
      len_d   = status_i.fill < LenStart;
    end
    if (state_q == ST_PAD) begin
      first_d = 1'b0;
      if (block_end) begin
        if (len_q) final_d = 1'b1;
        else       len_d   = 1'b1;
      end
    end
    if (out_done) begin
      pad_d   = 1'b0;
      len_d   = 1'b0;
      final_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
      idx_q   <= '0;
      pad_q   <= 1'b0;
      first_q <= 1'b0;
      len_q   <= 1'b0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      idx_q   <= idx_d;
      pad_q   <= pad_d;
      first_q <= first_d;
      len_q   <= len_d;
      final_q <= final_d;
    end
  end

  `ASSERT_CLK(a_no_overlap, clk_i, rst_ni, !(in_ready_o && out_valid_o), "ready while digest pending")
  `ASSERT_CLK(a_round_range, clk_i, rst_ni, round_q <= LastRound, "round count out of range")
  `ASSERT_CLK(a_idx_range, clk_i, rst_ni, idx_q <= LastWord, "word index out of range")
  `ASSERT_NEXT(a_update_next, clk_i, rst_ni, state_q == ST_UPDATE, state_q != ST_ROUND, "rounds restarted without a block")
  `ASSERT_CLK(a_out_final, clk_i, rst_ni, (state_q != ST_OUT) || final_q, "digest sent before final block")

endmodule

// ----- rtl/sha1_hash_engine.sv -----
// SHA-1 engine, one message byte per request, digest as five words.
// Bytes go in one per cycle while idle; each 64th byte then starts the 80
// rounds on the single round unit and the chaining-value update, during which
// input is refused. A finish request is accepted, then one padding byte per
// cycle goes in up to the end of each padded block (one or two),
// each followed by the rounds and the update; then the five digest words are
// offered on the output, one per accepted request. Input is refused while
// the digest is pending. No clearing pass is needed after reset.
module sha1_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] kind: 0 byte, 1 finish
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);
  import sha1he_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence the requests
  sha1he_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_index_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold block, counters and hash state
  sha1he_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .byte_i   (s_axis_tdata),
    .status_o (status),
    .digest_o (m_axis_tdata)
  );

endmodule
